// ===== design/fla_pkg.sv =====
// Package with the shared constants, types and command codes of the free-list block allocator.
package fla_pkg;

	localparam int HeapBytes = 4096;
	localparam int Granules  = HeapBytes / 8;
	localparam int GW        = $clog2(Granules);
	localparam int LW        = $clog2(HeapBytes) + 1;
	localparam int AW        = 12;
	localparam int SW        = 12;

	typedef logic [GW-1:0] gran_t;
	typedef logic [LW-1:0] len_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FHDR,
		ST_FCHK,
		ST_FRD,
		ST_FWAIT,
		ST_FEVAL,
		ST_ARD,
		ST_AWAIT,
		ST_AEVAL,
		ST_ASPLIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic fchk;
		logic frd;
		logic feval;
		logic ard;
		logic aeval;
		logic asplit;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic free_bad;
		logic free_head;
		logic free_stop;
		logic alloc_stop;
		logic found;
	} sts_t;

endpackage

// ===== design/fla_ctrl.sv =====
// Controller state machine that sequences the list walks of the allocator.
module fla_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_go,
	input  logic            cmd_free,
	input  logic            out_busy,
	input  fla_pkg::sts_t   sts,
	output fla_pkg::cmd_t   cmd,
	output logic            idle
);

	fla_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fla_pkg::ST_IDLE: begin
				if (in_go) state_d = cmd_free ? fla_pkg::ST_FHDR : fla_pkg::ST_ARD;
			end
			fla_pkg::ST_FHDR:  state_d = fla_pkg::ST_FCHK;
			fla_pkg::ST_FCHK: begin
				if (sts.free_bad || sts.is_free || sts.free_head) state_d = fla_pkg::ST_DONE;
				else state_d = fla_pkg::ST_FRD;
			end
			fla_pkg::ST_FRD:   state_d = fla_pkg::ST_FWAIT;
			fla_pkg::ST_FWAIT: state_d = fla_pkg::ST_FEVAL;
			fla_pkg::ST_FEVAL: state_d = sts.free_stop ? fla_pkg::ST_DONE : fla_pkg::ST_FRD;
			fla_pkg::ST_ARD:   state_d = fla_pkg::ST_AWAIT;
			fla_pkg::ST_AWAIT: state_d = fla_pkg::ST_AEVAL;
			fla_pkg::ST_AEVAL: begin
				if (sts.alloc_stop) state_d = sts.found ? fla_pkg::ST_ASPLIT : fla_pkg::ST_DONE;
				else state_d = fla_pkg::ST_ARD;
			end
			fla_pkg::ST_ASPLIT: state_d = fla_pkg::ST_DONE;
			fla_pkg::ST_DONE:   if (!out_busy) state_d = fla_pkg::ST_IDLE;
			default:            state_d = fla_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		unique case (state_q)
			fla_pkg::ST_IDLE:  begin idle = 1'b1; cmd.load = in_go; end
			fla_pkg::ST_FHDR:  cmd.frd = 1'b1;
			fla_pkg::ST_FCHK:  cmd.fchk = 1'b1;
			fla_pkg::ST_FRD:   cmd.frd = 1'b1;
			fla_pkg::ST_FEVAL: cmd.feval = 1'b1;
			fla_pkg::ST_ARD:   cmd.ard = 1'b1;
			fla_pkg::ST_AEVAL: cmd.aeval = 1'b1;
			fla_pkg::ST_ASPLIT: cmd.asplit = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== design/fla_dp.sv =====
// Datapath with the header memories, the free head and the walk registers.
module fla_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fla_pkg::cmd_t           cmd,
	input  logic                    fit_best,
	input  logic                    in_cmd,
	input  logic [fla_pkg::SW-1:0]  in_size,
	input  logic [fla_pkg::AW-1:0]  in_addr,
	input  logic                    res_load,
	output fla_pkg::sts_t           sts,
	output logic [fla_pkg::AW-1:0]  res_addr,
	output logic                    res_grant
);

	localparam int GW = fla_pkg::GW;
	localparam int LW = fla_pkg::LW;
	localparam int NW = fla_pkg::SW + 2;

	logic [LW-1:0] len_mem [fla_pkg::Granules];
	logic [GW:0]   link_mem [fla_pkg::Granules];
	logic          free_mem [fla_pkg::Granules];

	fla_pkg::gran_t head_q, cur_q, prev_q, sel_q, selp_q, hg_q, rd_q;
	logic           hasp_q, selhp_q, found_q, grant_q, cmd_q, init_q;
	logic [NW-1:0]  need_q;
	logic [LW:0]    mind_q;
	logic [LW-1:0]  len_s1, sel_len_q;
	logic [GW:0]    link_s1, sel_link_q;
	logic           free_s1, bad_q;
	logic [GW:0]    steps_q;

	logic [NW-1:0]  need_c;
	logic [NW:0]    ng_w;
	logic [LW:0]    diff_w;
	logic           linkv_rd, fits_first, fits_best, split_ok;
	logic [fla_pkg::AW:0] addr_off;

	assign need_c  = ((NW'(in_size) + NW'(7)) & ~NW'(7)) + NW'(16);
	assign linkv_rd = link_s1[GW];
	assign ng_w    = (NW+1)'(sel_q) + (NW+1)'(need_q >> 3);
	assign diff_w  = (LW+1)'(len_s1) - (LW+1)'(need_q);
	assign fits_first = (NW'(len_s1) >= need_q);
	assign fits_best  = (NW'(len_s1) > need_q) && (diff_w < mind_q);
	assign addr_off = (fla_pkg::AW+1)'(in_addr) - (fla_pkg::AW+1)'(16);
	assign split_ok = ng_w < (NW+1)'(fla_pkg::Granules);

	always_ff @(posedge clk) begin
		if (cmd.frd || cmd.ard) begin
			len_s1  <= len_mem[rd_q];
			link_s1 <= link_mem[rd_q];
			free_s1 <= free_mem[rd_q];
		end
		if (!init_q) begin
			len_mem[0]  <= LW'(fla_pkg::HeapBytes - 16);
			link_mem[0] <= '0;
			free_mem[0] <= 1'b1;
		end
		if (cmd.feval && sts.free_stop) begin
			link_mem[hg_q] <= link_s1;
			link_mem[cur_q] <= {1'b1, hg_q};
		end
		if (cmd.fchk && !bad_q && !free_s1 && hg_q < head_q)
			link_mem[hg_q] <= {1'b1, head_q};
		if (cmd.fchk && !bad_q && !free_s1) free_mem[hg_q] <= 1'b1;
		if (cmd.asplit && split_ok) begin
			len_mem[GW'(ng_w)]  <= sel_len_q - LW'(need_q);
			link_mem[GW'(ng_w)] <= sel_link_q;
			free_mem[GW'(ng_w)] <= 1'b1;
			len_mem[sel_q]  <= LW'(need_q - NW'(16));
			free_mem[sel_q] <= 1'b0;
			if (selhp_q) link_mem[selp_q] <= {1'b1, GW'(ng_w)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			init_q  <= 1'b0;
			grant_q <= 1'b0;
			res_grant <= 1'b0;
			res_addr <= '0;
		end else begin
			init_q <= 1'b1;
			if (cmd.load) grant_q <= 1'b0;
			if (cmd.fchk && !bad_q && !free_s1) begin
				grant_q <= 1'b1;
				if (hg_q < head_q) head_q <= hg_q;
			end
			if (cmd.asplit && split_ok) begin
				grant_q <= 1'b1;
				if (!selhp_q) head_q <= GW'(ng_w);
			end
			if (res_load) begin
				res_grant <= grant_q;
				res_addr  <= (grant_q && !cmd_q) ?
					fla_pkg::AW'({sel_q, 3'b000} + 16) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= in_cmd;
			need_q  <= need_c;
			hg_q    <= GW'(addr_off >> 3);
			bad_q   <= (in_addr < fla_pkg::AW'(16)) || (in_addr[2:0] != 3'b000) ||
				((addr_off >> 3) >= (fla_pkg::AW+1)'(fla_pkg::Granules));
			rd_q    <= in_cmd ? GW'(addr_off >> 3) : head_q;
			cur_q   <= head_q;
			hasp_q  <= 1'b0;
			found_q <= 1'b0;
			mind_q  <= (LW+1)'(fla_pkg::HeapBytes + 1);
			steps_q <= '0;
		end
		if (cmd.fchk) rd_q <= head_q;
		if (cmd.fchk) cur_q <= head_q;
		if (cmd.feval && !sts.free_stop) begin
			cur_q <= GW'(link_s1);
			rd_q  <= GW'(link_s1);
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.aeval) begin
			if ((!fit_best && fits_first && !found_q) || (fit_best && fits_best)) begin
				sel_q <= rd_q; selp_q <= prev_q; selhp_q <= hasp_q;
				found_q <= 1'b1; sel_len_q <= len_s1; sel_link_q <= link_s1;
				if (fit_best) mind_q <= diff_w;
			end
			prev_q <= rd_q; hasp_q <= 1'b1;
			rd_q <= GW'(link_s1);
			steps_q <= steps_q + 1'b1;
		end
	end

	always_comb begin
		sts.is_free   = free_s1;
		sts.free_bad  = bad_q;
		sts.free_head = hg_q < head_q;
		sts.free_stop = !linkv_rd || (GW'(link_s1) >= hg_q) ||
			(steps_q == (GW+1)'(fla_pkg::Granules - 1));
		sts.alloc_stop = (!fit_best && fits_first) || !linkv_rd ||
			(steps_q == (GW+1)'(fla_pkg::Granules - 1));
		sts.found     = found_q || (!fit_best && fits_first) || (fit_best && fits_best);
	end

endmodule

// ===== design/free_list_block_allocator.sv =====
// Top level of the free-list block allocator.
//  channel | signals                                          | dir
//  in      | in_valid in_ready command request_size block_address | in
//  out     | out_valid out_ready data_address granted        | out
//  cfg     | cfg_we cfg_wdata (fit_strategy)                 | in
// An allocate reads one free-list header per pass through its read, wait and evaluate
// states, then splits the chosen block, or gives its result beat when nothing fits.
// A free that is refused or goes to the head gives its beat right after the header check,
// otherwise once the walk reaches the insertion point; the next beat is taken in idle.
// The walk is set by the single read port of the header memory, and a stalled result
// beat holds the block until it is taken. After reset the heap is one free block.
module free_list_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [fla_pkg::SW-1:0]        request_size,
	input  logic [fla_pkg::AW-1:0]        block_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fla_pkg::AW-1:0]        data_address,
	output logic                          granted
);

	fla_pkg::cmd_t cmd;
	fla_pkg::sts_t sts;
	logic idle, fit_q, res_load, in_go;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fit_q <= 1'b0;
		else if (cfg_we) fit_q <= cfg_wdata;
	end

	assign in_ready = idle;
	assign in_go    = in_valid && idle;
	assign res_load = (cmd == '0) && !idle && !(out_valid && !out_ready) && done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (res_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd.load || res_load) done_q <= 1'b0;
			else if ((cmd.fchk && (sts.free_bad || sts.is_free || sts.free_head)) ||
				(cmd.feval && sts.free_stop) || cmd.asplit ||
				(cmd.aeval && sts.alloc_stop && !sts.found)) done_q <= 1'b1;
		end
	end

	fla_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .cmd_free(command),
		.out_busy(!res_load), .sts(sts), .cmd(cmd), .idle(idle)
	);

	fla_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .fit_best(fit_q),
		.in_cmd(command), .in_size(request_size), .in_addr(block_address),
		.res_load(res_load), .sts(sts), .res_addr(data_address), .res_grant(granted)
	);

endmodule

// ===== design/fla_checker.sv =====
// Port checker for the free-list block allocator and its bind.
module fla_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic granted,
	input logic [11:0] data_address
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_address))
		else $error("result beat dropped while stalled");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> data_address == 12'd0)
		else $error("refused request carries an address");
	a_al: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_address != 12'd0 |-> data_address[2:0] == 3'b000)
		else $error("address not aligned");
endmodule

bind free_list_block_allocator fla_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .granted(granted),
	.data_address(data_address)
);

// ===== tb/free_list_block_allocator_test.sv =====
// Self-checking testbench for the free-list block allocator, with directed and random beats.
`timescale 1ns / 100ps

module free_list_block_allocator_test;

	localparam int Limit = 6000000;

	typedef struct {
		logic        cmd;
		int          size;
		int          addr;
		bit          fixed;
		logic [11:0] exp_addr;
		logic        exp_grant;
	} row_t;

	typedef struct {
		logic [11:0] addr;
		logic        grant;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = fla_pkg::CMD_ALLOC;
	logic [fla_pkg::SW-1:0] request_size = '0;
	logic [fla_pkg::AW-1:0] block_address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [fla_pkg::AW-1:0] data_address;
	logic granted;

	int heap_len[fla_pkg::Granules];
	int heap_link[fla_pkg::Granules];
	bit heap_lv[fla_pkg::Granules];
	bit heap_free[fla_pkg::Granules];
	int heap_head;
	bit use_best;

	grant_t grants_due[$];
	int live_blocks[$];
	int freed_blocks[$];
	int errors = 0;
	int cycles = 0;
	int n_alloc = 0, n_free = 0, n_ok = 0;
	bit quiet = 1'b0;
	int out_idle = 0;
	row_t rows[$];

	free_list_block_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.request_size(request_size), .block_address(block_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_address(data_address), .granted(granted)
	);

	always #5 clk = ~clk;

	function automatic void heap_free_block(int addr, output grant_t g);
		int hg, cur, steps;
		g.addr = '0;
		g.grant = 1'b0;
		if (addr < 16 || addr % 8 != 0) return;
		hg = (addr - 16) >> 3;
		if (hg >= fla_pkg::Granules || heap_free[hg]) return;
		heap_free[hg] = 1'b1;
		if (hg < heap_head) begin
			heap_link[hg] = heap_head;
			heap_lv[hg] = 1'b1;
			heap_head = hg;
		end else begin
			cur = heap_head;
			for (steps = 0; steps < fla_pkg::Granules; steps++) begin
				if (!heap_lv[cur] || heap_link[cur] >= hg) break;
				cur = heap_link[cur];
			end
			heap_link[hg] = heap_link[cur];
			heap_lv[hg] = heap_lv[cur];
			heap_link[cur] = hg;
			heap_lv[cur] = 1'b1;
		end
		g.grant = 1'b1;
	endfunction

	function automatic void heap_alloc_block(int size, output grant_t g);
		int need, cur, prev, sel, sel_prev, ng, len, steps, mindiff;
		bit has_prev, found, sel_has_prev;
		need = ((size + 7) & ~7) + 16;
		cur = heap_head;
		prev = 0; sel = 0; sel_prev = 0;
		mindiff = fla_pkg::HeapBytes + 1;
		has_prev = 0; found = 0; sel_has_prev = 0;
		g.addr = '0;
		g.grant = 1'b0;
		for (steps = 0; steps < fla_pkg::Granules; steps++) begin
			len = heap_len[cur];
			if (!use_best) begin
				if (len >= need) begin
					sel = cur; sel_prev = prev; sel_has_prev = has_prev;
					found = 1;
					break;
				end
			end else if (len > need && len - need < mindiff) begin
				mindiff = len - need;
				sel = cur; sel_prev = prev; sel_has_prev = has_prev;
				found = 1;
			end
			if (!heap_lv[cur]) break;
			prev = cur;
			has_prev = 1;
			cur = heap_link[cur];
		end
		if (!found) return;
		len = heap_len[sel];
		ng = sel + (need >> 3);
		if (ng >= fla_pkg::Granules) return;
		heap_len[ng] = len - need;
		heap_link[ng] = heap_link[sel];
		heap_lv[ng] = heap_lv[sel];
		heap_free[ng] = 1'b1;
		if (sel_has_prev) begin
			heap_link[sel_prev] = ng;
			heap_lv[sel_prev] = 1'b1;
		end else begin
			heap_head = ng;
		end
		heap_len[sel] = need - 16;
		heap_lv[sel] = 1'b0;
		heap_free[sel] = 1'b0;
		g.addr = 12'((sel << 3) + 16);
		g.grant = 1'b1;
	endfunction

	function automatic grant_t heap_step(logic cmd, int size, int addr);
		grant_t g;
		if (cmd == fla_pkg::CMD_FREE) begin
			n_free++;
			heap_free_block(addr, g);
			if (g.grant) begin
				foreach (live_blocks[i]) if (live_blocks[i] == addr) begin
					live_blocks.delete(i);
					break;
				end
				if (freed_blocks.size() < 64) freed_blocks.push_back(addr);
			end
		end else begin
			n_alloc++;
			heap_alloc_block(size, g);
			if (g.grant) live_blocks.push_back(int'(g.addr));
		end
		if (g.grant) n_ok++;
		return g;
	endfunction

	task automatic send_beat(row_t r);
		grant_t g;
		bit hit;
		command <= r.cmd;
		request_size <= fla_pkg::SW'(r.size);
		block_address <= fla_pkg::AW'(r.addr);
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			hit = in_ready;
		end while (!hit);
		g = heap_step(r.cmd, r.size, r.addr);
		if (r.fixed) begin
			g.addr = r.exp_addr;
			g.grant = r.exp_grant;
		end
		grants_due.push_back(g);
		@(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic set_fit(bit v);
		in_valid <= 1'b0;
		while (grants_due.size() != 0) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		use_best = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic row_t random_beat();
		row_t r;
		int pick;
		r.fixed = 0; r.exp_addr = '0; r.exp_grant = 1'b0;
		r.size = $urandom_range(0, 4095);
		r.addr = $urandom_range(0, 4095) & ~7;
		pick = $urandom_range(0, 99);
		if (live_blocks.size() != 0 && pick < 45) begin
			r.cmd = fla_pkg::CMD_FREE;
			r.addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
		end else if (pick < 50) begin
			r.cmd = fla_pkg::CMD_FREE;
			if (freed_blocks.size() != 0 && pick < 47)
				r.addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
			else if (pick < 49)
				r.addr = $urandom_range(0, 4095) | 1 << $urandom_range(0, 2);
			else
				r.addr = $urandom_range(0, 15);
		end else begin
			r.cmd = fla_pkg::CMD_ALLOC;
			pick = $urandom_range(0, 99);
			if (pick < 70) r.size = $urandom_range(0, 120);
			else if (pick < 95) r.size = $urandom_range(121, 1000);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (out_idle > 0) begin
			out_idle <= out_idle - 1;
			out_ready <= out_idle == 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_idle <= $urandom_range(1, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		grant_t e;
		if (arst_n && out_valid && out_ready) begin
			if (grants_due.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = grants_due.pop_front();
				if (data_address !== e.addr) begin
					$error("data_address expected %0d actual %0d", e.addr, data_address);
					errors++;
				end
				if (granted !== e.grant) begin
					$error("granted expected %0d actual %0d", e.grant, granted);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= Limit) begin
			$display("free_list_block_allocator verification failed");
			$finish;
		end
	end

	initial begin
		heap_len[0] = fla_pkg::HeapBytes - 16;
		heap_free[0] = 1'b1;
		heap_head = 0;
		use_best = 1'b0;
		rows = '{
			'{fla_pkg::CMD_ALLOC, 4064, 0, 1, 12'd16, 1'b1},
			'{fla_pkg::CMD_ALLOC, 0, 0, 1, 12'd0, 1'b0},
			'{fla_pkg::CMD_FREE, 0, 16, 1, 12'd0, 1'b1},
			'{fla_pkg::CMD_ALLOC, 0, 4095, 1, 12'd16, 1'b1},
			'{fla_pkg::CMD_ALLOC, 4095, 0, 1, 12'd0, 1'b0},
			'{fla_pkg::CMD_FREE, 4095, 0, 1, 12'd0, 1'b0},
			'{fla_pkg::CMD_FREE, 0, 8, 1, 12'd0, 1'b0},
			'{fla_pkg::CMD_FREE, 0, 4095, 1, 12'd0, 1'b0},
			'{fla_pkg::CMD_FREE, 0, 20, 1, 12'd0, 1'b0},
			'{fla_pkg::CMD_FREE, 0, 16, 1, 12'd0, 1'b1},
			'{fla_pkg::CMD_FREE, 0, 16, 1, 12'd0, 1'b0},
			'{fla_pkg::CMD_ALLOC, 100, 0, 0, 12'd0, 1'b0},
			'{fla_pkg::CMD_ALLOC, 8, 0, 0, 12'd0, 1'b0},
			'{fla_pkg::CMD_ALLOC, 1, 0, 0, 12'd0, 1'b0},
			'{fla_pkg::CMD_ALLOC, 7, 0, 0, 12'd0, 1'b0},
			'{fla_pkg::CMD_FREE, 0, 32, 0, 12'd0, 1'b0},
			'{fla_pkg::CMD_ALLOC, 2000, 0, 0, 12'd0, 1'b0},
			'{fla_pkg::CMD_ALLOC, 3000, 0, 0, 12'd0, 1'b0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_fit(1'b0);
		foreach (rows[i]) send_beat(rows[i]);
		for (int phase = 0; phase < 4; phase++) begin
			set_fit(phase[0]);
			quiet = phase == 3;
			repeat (375) send_beat(random_beat());
		end
		in_valid <= 1'b0;
		while (grants_due.size() != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d allocates and %0d frees, %0d granted,", n_alloc, n_free, n_ok);
		$display("under first fit and best fit with random stalls on both sides.");
		if (errors == 0)
			$display("free_list_block_allocator verification clean");
		else
			$display("free_list_block_allocator verification failed");
		$finish;
	end

endmodule
